// File: design/mwe_pkg.sv
package mwe_pkg;

  localparam int MAX_ADDR_BITS = 11;
  localparam int SHIFT_W       = 22;
  localparam int COUNT_W       = 5;
  localparam int CAP_W         = 12;

  typedef enum logic [2:0] {
    CMD_NONE  = 3'd0,
    CMD_READ  = 3'd1,
    CMD_WRITE = 3'd2,
    CMD_WREN  = 3'd3,
    CMD_WRDS  = 3'd4
  } mwe_cmd_t;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_SHIFT,
    PH_CSLOW,
    PH_POLL,
    PH_CLEAR
  } mwe_phase_t;

  typedef enum logic [1:0] {
    AC_READ  = 2'd0,
    AC_WRITE = 2'd1,
    AC_WREN  = 2'd2,
    AC_WRDS  = 2'd3
  } mwe_active_t;

  typedef struct packed {
    logic [2:0]  command;
    logic [10:0] byte_address;
    logic [7:0]  write_byte;
    logic        data_in;
  } mwe_item_t;

  typedef struct packed {
    logic       chip_select;
    logic       data_out;
    logic       clock_pulse;
    logic       busy_res;
    logic [7:0] read_byte;
    logic       done_res;
    logic       refused;
  } mwe_result_t;

  // address length per size code, clamped to the widest supported address
  function automatic logic [3:0] addr_len(input logic [1:0] size_sel);
    logic [3:0] l;
    case (size_sel)
      2'd0:    l = 4'd7;
      2'd1:    l = 4'd9;
      2'd2:    l = 4'd9;
      default: l = 4'd11;
    endcase
    if (l > 4'(MAX_ADDR_BITS)) l = 4'(MAX_ADDR_BITS);
    return l;
  endfunction

  function automatic logic [CAP_W-1:0] capacity(input logic [1:0] size_sel);
    logic [CAP_W-1:0] c;
    logic [CAP_W-1:0] lim;
    case (size_sel)
      2'd0:    c = 12'd128;
      2'd1:    c = 12'd256;
      2'd2:    c = 12'd512;
      default: c = 12'd2048;
    endcase
    lim = CAP_W'(1) << addr_len(size_sel);
    return (c > lim) ? lim : c;
  endfunction

endpackage

// File: design/mwe_core.sv
module mwe_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                step_en,
  input  logic [1:0]          size_select,
  input  mwe_pkg::mwe_item_t   item,
  output mwe_pkg::mwe_result_t result
);

  mwe_pkg::mwe_phase_t               phase, phase_next;
  logic [mwe_pkg::COUNT_W-1:0]       bit_count, bit_count_next;
  logic [mwe_pkg::SHIFT_W-1:0]       out_shift, out_shift_next;
  logic [7:0]                        in_shift, in_shift_next;
  mwe_pkg::mwe_active_t              active_command, active_command_next;
  logic                              write_enabled, write_enabled_next;

  logic [3:0]                        len;
  logic [mwe_pkg::CAP_W-1:0]         cap;
  logic                              out_of_range;
  logic [mwe_pkg::SHIFT_W-1:0]       addr_field;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= mwe_pkg::PH_IDLE;
      bit_count      <= '0;
      out_shift      <= '0;
      in_shift       <= '0;
      active_command <= mwe_pkg::AC_READ;
      write_enabled  <= 1'b0;
    end else if (step_en) begin
      phase          <= phase_next;
      bit_count      <= bit_count_next;
      out_shift      <= out_shift_next;
      in_shift       <= in_shift_next;
      active_command <= active_command_next;
      write_enabled  <= write_enabled_next;
    end
  end

  assign len          = mwe_pkg::addr_len(size_select);
  assign cap          = mwe_pkg::capacity(size_select);
  assign out_of_range = {1'b0, item.byte_address} >= cap;
  assign addr_field   = mwe_pkg::SHIFT_W'(item.byte_address) << 8;

  always_comb begin
    phase_next          = phase;
    bit_count_next      = bit_count;
    out_shift_next      = out_shift;
    in_shift_next       = in_shift;
    active_command_next = active_command;
    write_enabled_next  = write_enabled;
    result              = '0;

    case (phase)
      mwe_pkg::PH_IDLE: begin
        case (item.command)
          mwe_pkg::CMD_READ: begin
            if (out_of_range) begin
              result.done_res = 1'b1;
            end else begin
              out_shift_next      = (mwe_pkg::SHIFT_W'(6) << ({1'b0, len} + 5'd8))
                                    | addr_field;
              bit_count_next      = mwe_pkg::COUNT_W'(len) + mwe_pkg::COUNT_W'(10);
              active_command_next = mwe_pkg::AC_READ;
            end
          end
          mwe_pkg::CMD_WRITE: begin
            if (!write_enabled || out_of_range) begin
              result.done_res = 1'b1;
              result.refused  = 1'b1;
            end else begin
              out_shift_next      = (mwe_pkg::SHIFT_W'(5) << ({1'b0, len} + 5'd8))
                                    | addr_field | mwe_pkg::SHIFT_W'(item.write_byte);
              bit_count_next      = mwe_pkg::COUNT_W'(len) + mwe_pkg::COUNT_W'(10);
              active_command_next = mwe_pkg::AC_WRITE;
            end
          end
          mwe_pkg::CMD_WREN: begin
            out_shift_next      = mwe_pkg::SHIFT_W'(8'h13) << (len - 4'd2);
            bit_count_next      = mwe_pkg::COUNT_W'(len) + mwe_pkg::COUNT_W'(2);
            active_command_next = mwe_pkg::AC_WREN;
          end
          mwe_pkg::CMD_WRDS: begin
            out_shift_next      = mwe_pkg::SHIFT_W'(4) << len;
            bit_count_next      = mwe_pkg::COUNT_W'(len) + mwe_pkg::COUNT_W'(2);
            active_command_next = mwe_pkg::AC_WRDS;
          end
          default: ;
        endcase
        // start bit goes out in the command's own period
        if ((item.command == mwe_pkg::CMD_WREN) || (item.command == mwe_pkg::CMD_WRDS)
            || ((item.command == mwe_pkg::CMD_READ) && !out_of_range)
            || ((item.command == mwe_pkg::CMD_WRITE) && write_enabled && !out_of_range)) begin
          in_shift_next      = '0;
          result.chip_select = 1'b1;
          result.data_out    = 1'b1;
          result.clock_pulse = 1'b1;
          phase_next         = mwe_pkg::PH_SHIFT;
        end
      end
      mwe_pkg::PH_SHIFT: begin
        if ((bit_count == '0) || (bit_count > mwe_pkg::COUNT_W'(mwe_pkg::SHIFT_W))) begin
          phase_next     = mwe_pkg::PH_IDLE;
          bit_count_next = '0;
        end else begin
          result.chip_select = 1'b1;
          result.clock_pulse = 1'b1;
          result.data_out    = out_shift[bit_count - 1'b1];
          if ((active_command == mwe_pkg::AC_READ) && (bit_count <= mwe_pkg::COUNT_W'(8)))
            in_shift_next = {in_shift[6:0], item.data_in};
          bit_count_next = bit_count - 1'b1;
          if (bit_count_next == '0) begin
            if (active_command == mwe_pkg::AC_WRITE) begin
              phase_next = mwe_pkg::PH_CSLOW;
            end else begin
              result.done_res = 1'b1;
              phase_next      = mwe_pkg::PH_IDLE;
              case (active_command)
                mwe_pkg::AC_READ: result.read_byte = in_shift_next;
                mwe_pkg::AC_WREN: write_enabled_next = 1'b1;
                default:          write_enabled_next = 1'b0;
              endcase
            end
          end
        end
      end
      mwe_pkg::PH_CSLOW: begin
        phase_next = mwe_pkg::PH_POLL;
      end
      mwe_pkg::PH_POLL: begin
        // hold select with no clocks until the device reports ready
        result.chip_select = 1'b1;
        if (item.data_in) phase_next = mwe_pkg::PH_CLEAR;
      end
      default: begin
        result.chip_select = 1'b1;
        result.data_out    = 1'b1;
        result.clock_pulse = 1'b1;
        result.done_res    = 1'b1;
        phase_next         = mwe_pkg::PH_IDLE;
      end
    endcase

    result.busy_res = (phase_next != mwe_pkg::PH_IDLE);
  end

endmodule

// File: design/microwire_eeprom_master_unit.sv
// Channel  | Handshake                       | Payload
// -------- | ------------------------------- | ------------------------------------------
// input    | in_valid / in_ready             | command, byte_address, write_byte, data_in
// result   | out_valid / out_ready           | chip_select, data_out, clock_pulse,
//          |                                 | busy_res, read_byte, done_res, refused
// config   | cfg_write_en / cfg_write_data   | size_select
//
// One transaction per cycle while out_ready stays high: an accepted item is held in the
// input register, its bit period is evaluated by the core logic and stored in the result
// register when the item advances, that is when the result register is free or being read.
// rst is synchronous, active high; it returns the bus sequencer to idle, disables writes
// and sets the size code to 0. A stalled result holds in the output register while one
// more item waits in the input register.
module microwire_eeprom_master_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write_en,
  input  logic [1:0]  cfg_write_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  command,
  input  logic [10:0] byte_address,
  input  logic [7:0]  write_byte,
  input  logic        data_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        chip_select,
  output logic        data_out,
  output logic        clock_pulse,
  output logic        busy_res,
  output logic [7:0]  read_byte,
  output logic        done_res,
  output logic        refused
);

  logic [1:0]           size_select;
  logic                 item_valid;
  mwe_pkg::mwe_item_t   item;
  mwe_pkg::mwe_result_t step_result;
  mwe_pkg::mwe_result_t result;
  logic                 advance;

  always_ff @(posedge clk) begin
    if (rst) size_select <= 2'd0;
    else if (cfg_write_en) size_select <= cfg_write_data;
  end

  assign advance  = item_valid && (!out_valid || out_ready);
  assign in_ready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      item_valid <= 1'b1;
    end else if (advance) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) item <= '{command, byte_address, write_byte, data_in};
  end

  mwe_core u_core (
    .clk         (clk),
    .rst         (rst),
    .step_en     (advance),
    .size_select (size_select),
    .item        (item),
    .result      (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) result <= step_result;
  end

  assign chip_select = result.chip_select;
  assign data_out    = result.data_out;
  assign clock_pulse = result.clock_pulse;
  assign busy_res    = result.busy_res;
  assign read_byte   = result.read_byte;
  assign done_res    = result.done_res;
  assign refused     = result.refused;

endmodule

// File: design/mwe_checker.sv
module mwe_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic       chip_select,
  input logic       data_out,
  input logic       clock_pulse,
  input logic       busy_res,
  input logic [7:0] read_byte,
  input logic       done_res,
  input logic       refused
);

  // a stalled result holds its bus levels
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(chip_select) && $stable(data_out)
      && $stable(clock_pulse) && $stable(read_byte) && $stable(done_res))
    else $error("result changed while stalled");

  a_refused_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && refused |-> done_res)
    else $error("refused without done");

  a_read_byte_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && (read_byte != 8'd0) |-> done_res)
    else $error("read byte outside completion");

  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && done_res |-> !busy_res)
    else $error("busy after completion");

  a_deselect_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && !chip_select |-> !data_out && !clock_pulse)
    else $error("bus activity while deselected");

endmodule

bind microwire_eeprom_master_unit mwe_checker u_mwe_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .chip_select (chip_select),
  .data_out    (data_out),
  .clock_pulse (clock_pulse),
  .busy_res    (busy_res),
  .read_byte   (read_byte),
  .done_res    (done_res),
  .refused     (refused)
);
